[sv/ssq_pkg.sv]
// ----------------------------------------------------------------------------
// ssq_pkg
// Types, codes and sizes shared by the SysEx acknowledged send queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int QCOUNT_W    = 7;

	// Frame: board, command, four data bytes
	localparam int FRAME_W = 48;
	localparam int MANUF_W = 24;
	localparam int TIMER_W = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_LIVE_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_PRESENT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_PRESENT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MANUFACTURER_ID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANSWER_TIMEOUT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BUSY_DELAY      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BUSY_CODE       = 3'd6;

	// Register reset values
	localparam logic [TIMER_W-1:0] ANSWER_TIMEOUT_RST = 16'd2000;
	localparam logic [TIMER_W-1:0] BUSY_DELAY_RST     = 16'd100;
	localparam logic [7:0]         BUSY_CODE_RST      = 8'd2;

	// Operation codes
	localparam logic [1:0] OP_SEND   = 2'd0;
	localparam logic [1:0] OP_ANSWER = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	typedef enum logic [1:0] {
		TM_STOPPED = 2'd0,
		TM_ANSWER  = 2'd1,
		TM_BUSY    = 2'd2
	} timer_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EVAL = 2'd1,
		ST_LOAD = 2'd2
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic cap_in;
		logic exec;
		logic load_mem;
	} ctl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic out_free;
		logic need_mem;
	} dp_status_t;

endpackage

[sv/sysex_ack_send_queue.sv]
// Result: registered by the evaluate step, or by a further load step when a frame comes out of
//   the registered read port of the queue memory; evaluate holds while the result is unaccepted.
//   A new item is taken only after the capture/evaluate/memory-read sequence of the last one.
// Reset (arst_n low): queue empty, no command outstanding, timer stopped, registers at defaults.
// The queue memory needs no clearing pass; only entries that hold a frame are read.
// ----------------------------------------------------------------------------
// sysex_ack_send_queue
// Stop-and-wait SysEx command sender with answer timeout and busy retry.
// ----------------------------------------------------------------------------
module sysex_ack_send_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_wr_en,
	input  logic [ssq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     operation,
	input  logic [7:0]                     board,
	input  logic [7:0]                     command,
	input  logic [7:0]                     data_one,
	input  logic [7:0]                     data_two,
	input  logic [7:0]                     data_three,
	input  logic [7:0]                     data_four,
	input  logic                           rx_is_sysex,
	input  logic [ssq_pkg::MANUF_W-1:0]    rx_manufacturer,
	input  logic [7:0]                     rx_status,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           transmit_valid,
	output logic [ssq_pkg::MANUF_W-1:0]    tx_manufacturer,
	output logic [7:0]                     tx_board,
	output logic [7:0]                     tx_command,
	output logic [7:0]                     tx_data_one,
	output logic [7:0]                     tx_data_two,
	output logic [7:0]                     tx_data_three,
	output logic [7:0]                     tx_data_four,
	output logic [ssq_pkg::QCOUNT_W-1:0]   queue_count,
	output logic                           timeout_error,
	output logic                           overflow_error
);

	// Sequence per transfer:
	//   capture - latch the item into the datapath
	//   evaluate - update queue, timer and outstanding command; hold here while
	//              the result register is still occupied
	//   load    - only when the oldest queued frame must be read from memory
	ssq_pkg::ctl_cmd_t   cmd;
	ssq_pkg::dp_status_t status;

	ssq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath owns the result register, so a finished result waits there
	// while the next item is already captured; its evaluation holds until the
	// register is free.
	ssq_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.operation       (operation),
		.board           (board),
		.command         (command),
		.data_one        (data_one),
		.data_two        (data_two),
		.data_three      (data_three),
		.data_four       (data_four),
		.rx_is_sysex     (rx_is_sysex),
		.rx_manufacturer (rx_manufacturer),
		.rx_status       (rx_status),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.transmit_valid  (transmit_valid),
		.tx_manufacturer (tx_manufacturer),
		.tx_board        (tx_board),
		.tx_command      (tx_command),
		.tx_data_one     (tx_data_one),
		.tx_data_two     (tx_data_two),
		.tx_data_three   (tx_data_three),
		.tx_data_four    (tx_data_four),
		.queue_count     (queue_count),
		.timeout_error   (timeout_error),
		.overflow_error  (overflow_error)
	);

endmodule

[sv/ssq_ctrl.sv]
// ----------------------------------------------------------------------------
// ssq_ctrl
// Sequencer: capture an item, evaluate it, fetch a queued frame if needed.
// ----------------------------------------------------------------------------
module ssq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ssq_pkg::dp_status_t status,
	output ssq_pkg::ctl_cmd_t   cmd
);

	ssq_pkg::state_t state_q;
	ssq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ssq_pkg::ST_EVAL;
				end
			end
			ssq_pkg::ST_EVAL: begin
				if (status.out_free) begin
					state_d = status.need_mem ? ssq_pkg::ST_LOAD : ssq_pkg::ST_IDLE;
				end
			end
			ssq_pkg::ST_LOAD: begin
				state_d = ssq_pkg::ST_IDLE;
			end
			default: begin
				state_d = ssq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ssq_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.cap_in = in_valid;
			end
			ssq_pkg::ST_EVAL: begin
				cmd.exec = status.out_free;
			end
			ssq_pkg::ST_LOAD: begin
				cmd.load_mem = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

[sv/ssq_datapath.sv]
// ----------------------------------------------------------------------------
// ssq_datapath
// Registers, frame queue memory, timer and result register of the sender.
// ----------------------------------------------------------------------------
module ssq_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ssq_pkg::ctl_cmd_t                 cmd,
	output ssq_pkg::dp_status_t               status,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [ssq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// input item
	input  logic [1:0]                        operation,
	input  logic [7:0]                        board,
	input  logic [7:0]                        command,
	input  logic [7:0]                        data_one,
	input  logic [7:0]                        data_two,
	input  logic [7:0]                        data_three,
	input  logic [7:0]                        data_four,
	input  logic                              rx_is_sysex,
	input  logic [ssq_pkg::MANUF_W-1:0]       rx_manufacturer,
	input  logic [7:0]                        rx_status,
	// result item
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              transmit_valid,
	output logic [ssq_pkg::MANUF_W-1:0]       tx_manufacturer,
	output logic [7:0]                        tx_board,
	output logic [7:0]                        tx_command,
	output logic [7:0]                        tx_data_one,
	output logic [7:0]                        tx_data_two,
	output logic [7:0]                        tx_data_three,
	output logic [7:0]                        tx_data_four,
	output logic [ssq_pkg::QCOUNT_W-1:0]      queue_count,
	output logic                              timeout_error,
	output logic                              overflow_error
);

	localparam int PW = ssq_pkg::PTR_W;
	localparam int CW = ssq_pkg::CNT_W;
	localparam int FW = ssq_pkg::FRAME_W;
	localparam int TW = ssq_pkg::TIMER_W;

	// configuration registers
	logic                      live_mode_q;
	logic                      output_present_q;
	logic                      input_present_q;
	logic [ssq_pkg::MANUF_W-1:0] manufacturer_id_q;
	logic [TW-1:0]             answer_timeout_q;
	logic [TW-1:0]             busy_delay_q;
	logic [7:0]                busy_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_mode_q       <= 1'b1;
			output_present_q  <= 1'b1;
			input_present_q   <= 1'b1;
			manufacturer_id_q <= '0;
			answer_timeout_q  <= ssq_pkg::ANSWER_TIMEOUT_RST;
			busy_delay_q      <= ssq_pkg::BUSY_DELAY_RST;
			busy_code_q       <= ssq_pkg::BUSY_CODE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ssq_pkg::REG_LIVE_MODE:       live_mode_q       <= cfg_wdata[0];
				ssq_pkg::REG_OUTPUT_PRESENT:  output_present_q  <= cfg_wdata[0];
				ssq_pkg::REG_INPUT_PRESENT:   input_present_q   <= cfg_wdata[0];
				ssq_pkg::REG_MANUFACTURER_ID: manufacturer_id_q <= cfg_wdata;
				ssq_pkg::REG_ANSWER_TIMEOUT:  answer_timeout_q  <= cfg_wdata[TW-1:0];
				ssq_pkg::REG_BUSY_DELAY:      busy_delay_q      <= cfg_wdata[TW-1:0];
				ssq_pkg::REG_BUSY_CODE:       busy_code_q       <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// captured input item
	logic [1:0]                  op_q;
	logic [FW-1:0]               in_frame_q;
	logic                        rx_is_sysex_q;
	logic [ssq_pkg::MANUF_W-1:0] rx_manufacturer_q;
	logic [7:0]                  rx_status_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q              <= operation;
			in_frame_q        <= {board, command, data_one, data_two, data_three, data_four};
			rx_is_sysex_q     <= rx_is_sysex;
			rx_manufacturer_q <= rx_manufacturer;
			rx_status_q       <= rx_status;
		end
	end

	// sender state
	logic [PW-1:0]        rp_q, rp_d;
	logic [PW-1:0]        wp_q, wp_d;
	logic [CW-1:0]        cnt_q, cnt_d, cnt_avail;
	logic [FW-1:0]        outst_q, outst_d;
	logic                 await_q, await_d;
	ssq_pkg::timer_mode_t tm_q, tm_d;
	logic [TW-1:0]        rem_q, rem_d;

	// frame queue memory
	logic [FW-1:0] mem [ssq_pkg::QUEUE_DEPTH];
	logic [FW-1:0] rd_data_q;

	// step decisions
	logic          emit;
	logic [FW-1:0] emit_frame;
	logic          ovf;
	logic          tout;
	logic          enq;
	logic          send_oldest;
	logic          need_mem;
	logic          match;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(ssq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign match = await_q && rx_is_sysex_q &&
		(rx_manufacturer_q == manufacturer_id_q) &&
		(in_frame_q[47:40] == outst_q[47:40]) &&
		(in_frame_q[39:32] == outst_q[39:32]);

	always_comb begin
		rp_d        = rp_q;
		wp_d        = wp_q;
		await_d     = await_q;
		tm_d        = tm_q;
		rem_d       = rem_q;
		outst_d     = outst_q;
		emit        = 1'b0;
		emit_frame  = '0;
		ovf         = 1'b0;
		tout        = 1'b0;
		enq         = 1'b0;
		send_oldest = 1'b0;
		need_mem    = 1'b0;

		case (op_q)
			ssq_pkg::OP_SEND: begin
				if (output_present_q && live_mode_q) begin
					if (!input_present_q) begin
						emit       = 1'b1;
						emit_frame = in_frame_q;
					end else if (cnt_q == CW'(ssq_pkg::QUEUE_DEPTH)) begin
						ovf = 1'b1;
					end else begin
						enq  = 1'b1;
						wp_d = next_ptr(wp_q);
						if (tm_q == ssq_pkg::TM_STOPPED) begin
							send_oldest = 1'b1;
						end
					end
				end
			end
			ssq_pkg::OP_ANSWER: begin
				if (match) begin
					if (rx_status_q == busy_code_q) begin
						tm_d  = ssq_pkg::TM_BUSY;
						rem_d = busy_delay_q;
					end else begin
						tm_d        = ssq_pkg::TM_STOPPED;
						rem_d       = '0;
						await_d     = 1'b0;
						send_oldest = 1'b1;
					end
				end
			end
			ssq_pkg::OP_TICK: begin
				if (tm_q != ssq_pkg::TM_STOPPED) begin
					if (rem_q <= TW'(1)) begin
						tm_d  = ssq_pkg::TM_STOPPED;
						rem_d = '0;
						if (tm_q == ssq_pkg::TM_BUSY) begin
							emit       = 1'b1;
							emit_frame = outst_q;
							tm_d       = ssq_pkg::TM_ANSWER;
							rem_d      = answer_timeout_q;
						end else begin
							tout        = 1'b1;
							await_d     = 1'b0;
							send_oldest = 1'b1;
						end
					end else begin
						rem_d = rem_q - 1'b1;
					end
				end
			end
			default: ;
		endcase

		cnt_avail = cnt_q + CW'(enq);
		cnt_d     = cnt_avail;
		if (send_oldest && (cnt_avail != '0)) begin
			rp_d    = next_ptr(rp_q);
			cnt_d   = cnt_avail - 1'b1;
			await_d = 1'b1;
			tm_d    = ssq_pkg::TM_ANSWER;
			rem_d   = answer_timeout_q;
			emit    = 1'b1;
			// an empty queue hands the new frame straight through
			if (enq && (cnt_q == '0)) begin
				emit_frame = in_frame_q;
				outst_d    = in_frame_q;
			end else begin
				need_mem = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			await_q <= 1'b0;
			tm_q    <= ssq_pkg::TM_STOPPED;
			rem_q   <= '0;
			outst_q <= '0;
		end else if (cmd.exec) begin
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			cnt_q   <= cnt_d;
			await_q <= await_d;
			tm_q    <= tm_d;
			rem_q   <= rem_d;
			outst_q <= outst_d;
		end else if (cmd.load_mem) begin
			outst_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && enq) begin
			mem[wp_q] <= in_frame_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_data_q <= mem[rp_q];
		end
	end

	// result register
	logic                        out_valid_q;
	logic                        tx_valid_q;
	logic [ssq_pkg::MANUF_W-1:0] tx_man_q;
	logic [FW-1:0]               tx_frame_q;
	logic [ssq_pkg::QCOUNT_W-1:0] qcount_q;
	logic                        tout_q;
	logic                        ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.exec && !need_mem) || cmd.load_mem) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			tx_valid_q <= emit;
			tx_man_q   <= emit ? manufacturer_id_q : '0;
			tx_frame_q <= emit_frame;
			qcount_q   <= ssq_pkg::QCOUNT_W'(cnt_d);
			tout_q     <= tout;
			ovf_q      <= ovf;
		end else if (cmd.load_mem) begin
			tx_frame_q <= rd_data_q;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign status.need_mem = need_mem;

	assign out_valid       = out_valid_q;
	assign transmit_valid  = tx_valid_q;
	assign tx_manufacturer = tx_man_q;
	assign tx_board        = tx_frame_q[47:40];
	assign tx_command      = tx_frame_q[39:32];
	assign tx_data_one     = tx_frame_q[31:24];
	assign tx_data_two     = tx_frame_q[23:16];
	assign tx_data_three   = tx_frame_q[15:8];
	assign tx_data_four    = tx_frame_q[7:0];
	assign queue_count     = qcount_q;
	assign timeout_error   = tout_q;
	assign overflow_error  = ovf_q;

endmodule

[test/ack_queue_monitor.sv]
// ----------------------------------------------------------------------------
// ack_queue_monitor
// Watches both channels and the register port of the SysEx send queue,
// predicts every result from its own model of the queue and the timers,
// and compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ack_queue_monitor
	import ssq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [1:0]            operation,
	input  logic [7:0]            board,
	input  logic [7:0]            command,
	input  logic [7:0]            data_one,
	input  logic [7:0]            data_two,
	input  logic [7:0]            data_three,
	input  logic [7:0]            data_four,
	input  logic                  rx_is_sysex,
	input  logic [MANUF_W-1:0]    rx_manufacturer,
	input  logic [7:0]            rx_status,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  transmit_valid,
	input  logic [MANUF_W-1:0]    tx_manufacturer,
	input  logic [7:0]            tx_board,
	input  logic [7:0]            tx_command,
	input  logic [7:0]            tx_data_one,
	input  logic [7:0]            tx_data_two,
	input  logic [7:0]            tx_data_three,
	input  logic [7:0]            tx_data_four,
	input  logic [QCOUNT_W-1:0]   queue_count,
	input  logic                  timeout_error,
	input  logic                  overflow_error,
	output int                    fail_count,
	output int                    pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                transmit;
		logic [MANUF_W-1:0]  manuf;
		logic [7:0]          board;
		logic [7:0]          command;
		logic [7:0]          d1;
		logic [7:0]          d2;
		logic [7:0]          d3;
		logic [7:0]          d4;
		logic [QCOUNT_W-1:0] qcount;
		logic                tmo_err;
		logic                ovf_err;
	} queue_result_t;

	// model of the queue and the timers
	logic [FRAME_W-1:0] frame_store [QUEUE_DEPTH];
	logic [PTR_W-1:0]   rd_ptr;
	logic [PTR_W-1:0]   wr_ptr;
	logic [CNT_W-1:0]   waiting;
	logic [FRAME_W-1:0] in_flight;
	logic               awaiting;
	timer_mode_t        tmr_mode;
	logic [TIMER_W-1:0] tmr_left;

	// register copies
	logic               live;
	logic               out_present;
	logic               in_present;
	logic [MANUF_W-1:0] cfg_manuf;
	logic [TIMER_W-1:0] tmo_len;
	logic [TIMER_W-1:0] busy_len;
	logic [7:0]         busy_val;

	queue_result_t result_queue [$];
	int fails;
	int reports;

	assign fail_count = fails;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	task automatic put_frame(inout queue_result_t r, input logic [FRAME_W-1:0] f);
		r.transmit = 1'b1;
		r.manuf    = cfg_manuf;
		{r.board, r.command, r.d1, r.d2, r.d3, r.d4} = f;
	endtask

	// Pop the oldest queued frame, make it outstanding and send it.
	task automatic launch_oldest(inout queue_result_t r);
		if (waiting != 0) begin
			in_flight = frame_store[rd_ptr];
			rd_ptr    = next_ptr(rd_ptr);
			waiting   = waiting - 1'b1;
			awaiting  = 1'b1;
			put_frame(r, in_flight);
			tmr_mode  = TM_ANSWER;
			tmr_left  = tmo_len;
		end
	endtask

	task automatic predict_result(output queue_result_t r);
		logic [FRAME_W-1:0] f;
		logic               hit;
		r = '0;
		f = {board, command, data_one, data_two, data_three, data_four};
		case (operation)
			OP_SEND: begin
				if (out_present && live) begin
					if (!in_present) begin
						put_frame(r, f);
					end else if (waiting >= QUEUE_DEPTH) begin
						r.ovf_err = 1'b1;
					end else begin
						frame_store[wr_ptr] = f;
						wr_ptr  = next_ptr(wr_ptr);
						waiting = waiting + 1'b1;
						if (tmr_mode == TM_STOPPED)
							launch_oldest(r);
					end
				end
			end
			OP_ANSWER: begin
				hit = awaiting && rx_is_sysex && (rx_manufacturer == cfg_manuf) &&
					(board == in_flight[47:40]) && (command == in_flight[39:32]);
				if (hit) begin
					if (rx_status == busy_val) begin
						tmr_mode = TM_BUSY;
						tmr_left = busy_len;
					end else begin
						tmr_mode = TM_STOPPED;
						tmr_left = '0;
						awaiting = 1'b0;
						launch_oldest(r);
					end
				end
			end
			OP_TICK: begin
				if (tmr_mode != TM_STOPPED) begin
					if (tmr_left <= 1) begin
						if (tmr_mode == TM_BUSY) begin
							put_frame(r, in_flight);
							tmr_mode = TM_ANSWER;
							tmr_left = tmo_len;
						end else begin
							tmr_mode  = TM_STOPPED;
							tmr_left  = '0;
							r.tmo_err = 1'b1;
							awaiting  = 1'b0;
							launch_oldest(r);
						end
					end else begin
						tmr_left = tmr_left - 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.qcount = QCOUNT_W'(waiting);
	endtask

	task automatic show_result(input string tag, input queue_result_t r);
		$display("  %s: tx=%0d manuf=%h frame=%h %h %h %h %h %h count=%0d tmo=%0d ovf=%0d",
			tag, r.transmit, r.manuf, r.board, r.command, r.d1, r.d2, r.d3, r.d4,
			r.qcount, r.tmo_err, r.ovf_err);
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t predicted;
		queue_result_t seen;
		if (!arst_n) begin
			rd_ptr      = '0;
			wr_ptr      = '0;
			waiting     = '0;
			in_flight   = '0;
			awaiting    = 1'b0;
			tmr_mode    = TM_STOPPED;
			tmr_left    = '0;
			live        = 1'b1;
			out_present = 1'b1;
			in_present  = 1'b1;
			cfg_manuf   = '0;
			tmo_len     = ANSWER_TIMEOUT_RST;
			busy_len    = BUSY_DELAY_RST;
			busy_val    = BUSY_CODE_RST;
			fails       = 0;
			reports     = 0;
			result_queue.delete();
			pending_results <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_LIVE_MODE:       live        = cfg_wdata[0];
					REG_OUTPUT_PRESENT:  out_present = cfg_wdata[0];
					REG_INPUT_PRESENT:   in_present  = cfg_wdata[0];
					REG_MANUFACTURER_ID: cfg_manuf   = cfg_wdata[MANUF_W-1:0];
					REG_ANSWER_TIMEOUT:  tmo_len     = cfg_wdata[TIMER_W-1:0];
					REG_BUSY_DELAY:      busy_len    = cfg_wdata[TIMER_W-1:0];
					REG_BUSY_CODE:       busy_val    = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_result(predicted);
				result_queue.push_back(predicted);
			end
			if (out_valid && !out_stall) begin
				seen = {transmit_valid, tx_manufacturer, tx_board, tx_command, tx_data_one,
					tx_data_two, tx_data_three, tx_data_four, queue_count, timeout_error,
					overflow_error};
				if (result_queue.size() == 0) begin
					fails++;
					if (reports < 10) begin
						$display("%0t: result transfer with nothing predicted", $realtime);
						show_result("actual", seen);
					end
					reports++;
				end else begin
					predicted = result_queue.pop_front();
					if (seen !== predicted) begin
						fails++;
						if (reports < 10) begin
							$display("%0t: result mismatch", $realtime);
							show_result("expected", predicted);
							show_result("actual  ", seen);
						end
						reports++;
					end
				end
			end
			pending_results <= result_queue.size();
		end
	end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the SysEx acknowledged send queue with a directed opening and then
// random command, answer and tick traffic over several register settings,
// with bursty input and a patterned output stall; the monitor beside the
// block predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ssq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	// operation code the block ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// receiver stall patterns
	localparam int STALL_NONE   = 0;
	localparam int STALL_LIGHT  = 1;
	localparam int STALL_HEAVY  = 2;
	localparam int STALL_TOGGLE = 3;

	// one input item as the sender sees it
	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         board;
		logic [7:0]         command;
		logic [7:0]         d1;
		logic [7:0]         d2;
		logic [7:0]         d3;
		logic [7:0]         d4;
		logic               sysex;
		logic [MANUF_W-1:0] manuf;
		logic [7:0]         status;
	} midi_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            operation = '0;
	logic [7:0]            board = '0;
	logic [7:0]            command = '0;
	logic [7:0]            data_one = '0;
	logic [7:0]            data_two = '0;
	logic [7:0]            data_three = '0;
	logic [7:0]            data_four = '0;
	logic                  rx_is_sysex = 1'b0;
	logic [MANUF_W-1:0]    rx_manufacturer = '0;
	logic [7:0]            rx_status = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  transmit_valid;
	logic [MANUF_W-1:0]    tx_manufacturer;
	logic [7:0]            tx_board;
	logic [7:0]            tx_command;
	logic [7:0]            tx_data_one;
	logic [7:0]            tx_data_two;
	logic [7:0]            tx_data_three;
	logic [7:0]            tx_data_four;
	logic [QCOUNT_W-1:0]   queue_count;
	logic                  timeout_error;
	logic                  overflow_error;

	int fail_count;
	int pending_results;

	// sender bookkeeping used to shape answers that can match
	logic [MANUF_W-1:0] cur_manuf = '0;
	logic [7:0]         cur_code  = BUSY_CODE_RST;
	logic [15:0]        last_tx_key = '0;
	logic [15:0]        recent_keys [4] = '{default: '0};
	logic [1:0]         recent_slot = '0;
	int                 burst_left  = 0;

	int stall_mode = STALL_NONE;
	int stall_span = 0;
	int idle_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sysex_ack_send_queue uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.board           (board),
		.command         (command),
		.data_one        (data_one),
		.data_two        (data_two),
		.data_three      (data_three),
		.data_four       (data_four),
		.rx_is_sysex     (rx_is_sysex),
		.rx_manufacturer (rx_manufacturer),
		.rx_status       (rx_status),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.transmit_valid  (transmit_valid),
		.tx_manufacturer (tx_manufacturer),
		.tx_board        (tx_board),
		.tx_command      (tx_command),
		.tx_data_one     (tx_data_one),
		.tx_data_two     (tx_data_two),
		.tx_data_three   (tx_data_three),
		.tx_data_four    (tx_data_four),
		.queue_count     (queue_count),
		.timeout_error   (timeout_error),
		.overflow_error  (overflow_error)
	);

	ack_queue_monitor monitor (.*);

	// Remember the last frame put on the wire: it is usually the outstanding one,
	// so answers built from it have a good chance to match.
	always @(posedge clk) begin
		if (out_valid && !out_stall && transmit_valid)
			last_tx_key <= {tx_board, tx_command};
	end

	// Receiver: switch among stall patterns at random times, so that
	// stalls land on every phase of the block's work, with clean stretches too.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= STALL_NONE;
			stall_span <= 0;
		end else begin
			if (stall_span == 0) begin
				stall_mode <= $urandom_range(STALL_NONE, STALL_TOGGLE);
				stall_span <= $urandom_range(20, 200);
			end else begin
				stall_span <= stall_span - 1;
			end
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ~out_stall;
			endcase
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Present one item and hold it until the transfer. Between bursts drop valid
	// for a random gap; a zero gap keeps valid high straight into the next burst.
	task automatic transfer_item(input midi_event_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(10, 60);
		end
		burst_left--;
		in_valid        <= 1'b1;
		operation       <= it.op;
		board           <= it.board;
		command         <= it.command;
		data_one        <= it.d1;
		data_two        <= it.d2;
		data_three      <= it.d3;
		data_four       <= it.d4;
		rx_is_sysex     <= it.sysex;
		rx_manufacturer <= it.manuf;
		rx_status       <= it.status;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (it.op == OP_SEND) begin
			recent_keys[recent_slot] = {it.board, it.command};
			recent_slot = recent_slot + 2'd1;
		end
	endtask

	task automatic push_event(input logic [1:0] op, input logic [7:0] b, c,
		input logic [31:0] data, input logic sx, input logic [MANUF_W-1:0] mf,
		input logic [7:0] st);
		midi_event_t it;
		it.op      = op;
		it.board   = b;
		it.command = c;
		{it.d1, it.d2, it.d3, it.d4} = data;
		it.sysex   = sx;
		it.manuf   = mf;
		it.status  = st;
		transfer_item(it);
	endtask

	// Drop valid and hold until every predicted result has come out, then let
	// the pipeline drain. The first edge lets the monitor count the last transfer.
	task automatic wait_idle();
		in_valid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Rewrite every register, only once the block has gone quiet.
	task automatic configure(input logic live, outp, inp, input logic [MANUF_W-1:0] mf,
		input logic [TIMER_W-1:0] tmo, busy, input logic [7:0] code);
		wait_idle();
		write_reg(REG_LIVE_MODE, CFG_DATA_W'(live));
		write_reg(REG_OUTPUT_PRESENT, CFG_DATA_W'(outp));
		write_reg(REG_INPUT_PRESENT, CFG_DATA_W'(inp));
		write_reg(REG_MANUFACTURER_ID, CFG_DATA_W'(mf));
		write_reg(REG_ANSWER_TIMEOUT, CFG_DATA_W'(tmo));
		write_reg(REG_BUSY_DELAY, CFG_DATA_W'(busy));
		write_reg(REG_BUSY_CODE, CFG_DATA_W'(code));
		cfg_wr_en <= 1'b0;
		cur_manuf = mf;
		cur_code  = code;
	endtask

	// Mostly well-formed traffic: commands on a few popular boards, answers aimed
	// at the outstanding command, ticks to run the timers; the rest is noise,
	// including the unused operation code.
	function automatic midi_event_t random_item(input int send_pct);
		midi_event_t it;
		int roll;
		int pick;
		it.op      = 2'($urandom);
		it.board   = 8'($urandom);
		it.command = 8'($urandom);
		it.d1      = 8'($urandom);
		it.d2      = 8'($urandom);
		it.d3      = 8'($urandom);
		it.d4      = 8'($urandom);
		it.sysex   = 1'($urandom);
		it.manuf   = MANUF_W'($urandom);
		it.status  = 8'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < send_pct) begin
			it.op = OP_SEND;
			if ($urandom_range(0, 1))
				it.board = 8'($urandom_range(0, 3));
			if ($urandom_range(0, 1))
				it.command = 8'($urandom_range(0, 3));
		end else if (roll < send_pct + (100 - send_pct) * 45 / 100) begin
			it.op    = OP_ANSWER;
			it.sysex = ($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 9) != 0)
				it.manuf = cur_manuf;
			pick = $urandom_range(0, 9);
			if (pick < 5)
				{it.board, it.command} = last_tx_key;
			else if (pick < 8)
				{it.board, it.command} = recent_keys[2'($urandom_range(0, 3))];
			if ($urandom_range(0, 2) == 0)
				it.status = cur_code;
		end else if (roll < send_pct + (100 - send_pct) * 85 / 100) begin
			it.op = OP_TICK;
		end
		return it;
	endfunction

	task automatic run_phase(input int count, input int send_pct);
		repeat (count) transfer_item(random_item(send_pct));
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: unused operation, idle tick, stray answer, then a command
		// sent at once, a busy answer and a clearing answer during the busy delay.
		push_event(OP_UNUSED, 8'hFF, 8'hFF, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 8'hFF);
		push_event(OP_TICK, 8'h00, 8'h00, 32'h0, 1'b0, 24'h0, 8'h00);
		push_event(OP_ANSWER, 8'h00, 8'h00, 32'h0, 1'b1, 24'h0, 8'h00);
		push_event(OP_SEND, 8'hFF, 8'hFF, 32'hFFFFFFFF, 1'b0, 24'h0, 8'h00);
		push_event(OP_ANSWER, 8'hFF, 8'hFF, 32'h0, 1'b1, 24'h0, BUSY_CODE_RST);
		push_event(OP_ANSWER, 8'hFF, 8'hFF, 32'h0, 1'b1, 24'h0, 8'h00);

		// Zero timer lengths act as one tick.
		configure(1'b1, 1'b1, 1'b1, 24'hA55AC3, 16'd0, 16'd0, 8'hFF);
		push_event(OP_SEND, 8'h00, 8'h00, 32'h00000000, 1'b0, 24'h0, 8'h00);
		push_event(OP_SEND, 8'h12, 8'h34, 32'h56789ABC, 1'b0, 24'h0, 8'h00);
		// near misses: not SysEx, wrong manufacturer, wrong board
		push_event(OP_ANSWER, 8'h00, 8'h00, 32'h0, 1'b0, 24'hA55AC3, 8'h00);
		push_event(OP_ANSWER, 8'h00, 8'h00, 32'h0, 1'b1, 24'h5AA53C, 8'h00);
		push_event(OP_ANSWER, 8'h01, 8'h00, 32'h0, 1'b1, 24'hA55AC3, 8'h00);
		// busy, resend on the next tick, then acknowledge and send the queued one
		push_event(OP_ANSWER, 8'h00, 8'h00, 32'h0, 1'b1, 24'hA55AC3, 8'hFF);
		push_event(OP_TICK, 8'h00, 8'h00, 32'h0, 1'b0, 24'h0, 8'h00);
		push_event(OP_ANSWER, 8'h00, 8'h00, 32'h0, 1'b1, 24'hA55AC3, 8'h00);
		// answer timer runs out with an empty queue
		push_event(OP_TICK, 8'h00, 8'h00, 32'h0, 1'b0, 24'h0, 8'h00);
		push_event(OP_TICK, 8'h00, 8'h00, 32'h0, 1'b0, 24'h0, 8'h00);

		// offline editing refuses commands
		configure(1'b0, 1'b1, 1'b1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
		push_event(OP_SEND, 8'h5A, 8'hA5, 32'h01020304, 1'b0, 24'h0, 8'h00);
		// no output device refuses commands
		configure(1'b1, 1'b0, 1'b1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
		push_event(OP_SEND, 8'h5A, 8'hA5, 32'h01020304, 1'b0, 24'h0, 8'h00);
		// no answer port: send at once, answers are ignored
		configure(1'b1, 1'b1, 1'b0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
		push_event(OP_SEND, 8'hAA, 8'h55, 32'hF00F0FF0, 1'b0, 24'h0, 8'h00);
		push_event(OP_ANSWER, 8'hAA, 8'h55, 32'h0, 1'b1, 24'hFFFFFF, 8'h01);

		// Random part over several settings.
		configure(1'b1, 1'b1, 1'b1, 24'hFFFFFF, 16'd3, 16'd2, 8'h00);
		run_phase(90, 40);
		configure(1'b1, 1'b1, 1'b1, 24'h000000, 16'd1, 16'd1, 8'hFF);
		run_phase(90, 40);
		// long timers and almost only commands: fill the queue past full
		configure(1'b1, 1'b1, 1'b1, MANUF_W'($urandom), 16'hFFFF, 16'hFFFF, 8'($urandom));
		run_phase(120, 95);
		configure(1'b1, 1'b1, 1'b0, MANUF_W'($urandom), TIMER_W'($urandom_range(1, 8)),
			TIMER_W'($urandom_range(1, 6)), 8'($urandom));
		run_phase(60, 50);
		configure(1'b0, 1'b1, 1'b1, cur_manuf, TIMER_W'($urandom_range(1, 8)),
			TIMER_W'($urandom_range(1, 6)), cur_code);
		run_phase(40, 50);
		configure(1'b1, 1'b0, 1'b1, cur_manuf, TIMER_W'($urandom_range(1, 8)),
			TIMER_W'($urandom_range(1, 6)), cur_code);
		run_phase(40, 50);
		// drain what is left with short timers
		configure(1'b1, 1'b1, 1'b1, MANUF_W'($urandom), TIMER_W'($urandom_range(1, 8)),
			TIMER_W'($urandom_range(1, 6)), 8'($urandom));
		run_phase(100, 35);
		configure(1'b1, 1'b1, 1'b1, MANUF_W'($urandom), 16'd2, 16'hFFFF, 8'($urandom));
		run_phase(60, 40);

		wait_idle();
		if (fail_count == 0 && pending_results == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
